@@ rtl/kblr_pkg.sv @@
`default_nettype none
package kblr_pkg;

   localparam int KEY_CODES_DEF = 256;
   localparam int MAX_HELD_DEF = 16;
   localparam int MAX_RESULTS = 40;
   localparam int CODE_W = 8;
   localparam int CODE_SPACE = 256;
   localparam int MAP_DEPTH = CODE_SPACE * 4;
   localparam int MAP_AW = $clog2(MAP_DEPTH);
   localparam int MAP_W = 10;
   localparam int NRES_W = $clog2(MAX_RESULTS + 1);
   localparam logic [CODE_W-1:0] DEFAULT_SHIFT_CODE = 8'd42;

   localparam logic [1:0] REQ_EVENT = 2'd0;
   localparam logic [1:0] REQ_MAP = 2'd1;
   localparam logic [1:0] REQ_CLASS = 2'd2;

   localparam logic [1:0] ACT_RELEASE = 2'd0;
   localparam logic [1:0] ACT_PRESS = 2'd1;

   localparam logic [1:0] CLS_NORMAL = 2'd0;
   localparam logic [1:0] CLS_SHIFT = 2'd1;
   localparam logic [1:0] CLS_ALTGR = 2'd2;

   localparam logic [1:0] PASS_MOD_REL = 2'd0;
   localparam logic [1:0] PASS_MOD_PRS = 2'd1;
   localparam logic [1:0] PASS_KEY_REL = 2'd2;
   localparam logic [1:0] PASS_KEY_PRS = 2'd3;

   typedef struct packed {
      logic              held;
      logic              has_out;
      logic [CODE_W-1:0] target;
      logic              needs_shift;
   } held_type;

   localparam int HELD_W = $bits(held_type);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_RD,
      ST_A_EV,
      ST_U_RD,
      ST_U_WR,
      ST_B_RD1,
      ST_B_RD2,
      ST_B_EV,
      ST_DEC,
      ST_D_RD,
      ST_D_EV,
      ST_FLUSH
   } state_type;

endpackage
`default_nettype wire

@@ rtl/kblr_chan_if.sv @@
`default_nettype none
interface kblr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] key_code;
   logic [1:0] action;
   logic       entry_shift;
   logic       entry_altgr;
   logic       entry_found;
   logic [7:0] entry_target;
   logic       entry_needs_shift;
   logic [1:0] class_value;
   modport source (output valid, req_type, key_code, action, entry_shift, entry_altgr,
                   entry_found, entry_target, entry_needs_shift, class_value, input ready);
   modport sink (input valid, req_type, key_code, action, entry_shift, entry_altgr,
                 entry_found, entry_target, entry_needs_shift, class_value, output ready);
endinterface

interface kblr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_code;
   logic       out_pressed;
   logic       last;
   modport source (output valid, out_code, out_pressed, last, input ready);
   modport sink (input valid, out_code, out_pressed, last, output ready);
endinterface

interface kblr_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] wdata;
   modport source (output valid, wdata, input ready);
   modport sink (input valid, wdata, output ready);
endinterface
`default_nettype wire

@@ rtl/keyboard_layout_remapper.sv @@
`default_nettype none
// Keyboard layout remapper.
// req_chan carries one word per request: a key event, a mapping-table write or
// a key-class write. rsp_chan returns the resulting key changes as words of
// (out_code, out_pressed, last): modifier releases, modifier presses, key
// releases, key presses, each in ascending code order, at most 40 per event,
// with last set on the final one. A table write or an event that changes
// nothing returns no word. csr_chan writes the code sent for a forced shift; it
// is always ready and should only be written while the block is idle.
// A table write is done as the request is accepted. For a key event one
// sequencer walks the 256-entry held and class stores twice (one memory read
// port each) and compares the old and new output sets in four passes.
// After reset a clearing pass over all 1024 table addresses empties all
// stores; req_chan is not ready meanwhile. A stalled receiver holds the output
// register, and the difference scan waits if it finds a word while one is
// pending; the last word may still wait while the next request is accepted.
module keyboard_layout_remapper import kblr_pkg::*; #(
   parameter int KEY_CODES = KEY_CODES_DEF,
   parameter int MAX_HELD = MAX_HELD_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   kblr_req_if.sink   req_chan,
   kblr_rsp_if.source rsp_chan,
   kblr_csr_if.sink   csr_chan
);

   logic [CODE_W-1:0] shift_out_ff, shift_out_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      shift_out_in = shift_out_ff;
      if (csr_chan.valid) shift_out_in = csr_chan.wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_out_ff <= DEFAULT_SHIFT_CODE;
      end else begin
         shift_out_ff <= shift_out_in;
      end
   end

   kblr_core #(.KEY_CODES(KEY_CODES), .MAX_HELD(MAX_HELD)) u_core (
      .clock,
      .reset,
      .shift_out_code(shift_out_ff),
      .req_chan,
      .rsp_chan
   );

endmodule
`default_nettype wire

@@ rtl/kblr_ram.sv @@
`default_nettype none
module kblr_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ rtl/kblr_core.sv @@
`default_nettype none
module kblr_core import kblr_pkg::*; #(
   parameter int KEY_CODES = KEY_CODES_DEF,
   parameter int MAX_HELD = MAX_HELD_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [CODE_W-1:0] shift_out_code,
   kblr_req_if.sink               req_chan,
   kblr_rsp_if.source             rsp_chan
);

   localparam int HC_W = $clog2(MAX_HELD + 1);

   state_type state_ff, state_in;
   logic [MAP_AW-1:0] clr_ff, clr_in;
   logic [CODE_W-1:0] idx_ff, idx_in;
   logic [1:0] pass_ff, pass_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [1:0] action_ff, action_in;
   logic [HC_W-1:0] hcount_ff, hcount_in;
   logic shdn_ff, shdn_in, agdn_ff, agdn_in, shdn2_ff, shdn2_in;
   logic any_mod_ff, any_mod_in, need_s_ff, need_s_in, need_ns_ff, need_ns_in;
   logic suppress_ff, suppress_in;
   held_type hb_ff, hb_in;
   logic [NRES_W-1:0] n_ff, n_in;
   logic pend_valid_ff, pend_valid_in, pend_pr_ff, pend_pr_in;
   logic [CODE_W-1:0] pend_code_ff, pend_code_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_pr_ff, rsp_pr_in, rsp_last_ff, rsp_last_in;
   logic [CODE_W-1:0] rsp_code_ff, rsp_code_in;

   logic held_we, cls_we, map_we, newk_we, newm_we, oldk_we, oldm_we;
   logic [CODE_W-1:0] held_waddr, held_raddr, cls_waddr, cls_raddr, newk_waddr, newm_waddr;
   logic [MAP_AW-1:0] map_waddr, map_raddr;
   held_type held_wdata, held_rd;
   logic [HELD_W-1:0] held_rdata;
   logic [1:0] cls_wdata, cls_rdata;
   logic [MAP_W-1:0] map_wdata, map_rdata;
   logic newk_wdata, newm_wdata, oldk_wdata, oldm_wdata;
   logic newk_rd, newm_rd, oldk_rd, oldm_rd;

   logic accept, out_free, nk_eff, o_bit, n_bit, hit, take, advance, push_mid, push_last;
   logic is_key_pass, is_press_pass;

   function automatic logic [1:0] cls_eff(input logic [CODE_W-1:0] code, input logic [1:0] cl);
      return (32'(code) < KEY_CODES) ? cl : CLS_NORMAL;
   endfunction

   assign held_rd = held_type'(held_rdata);

   kblr_ram #(.WIDTH(HELD_W), .DEPTH(CODE_SPACE)) u_held (
      .clock, .we(held_we), .waddr(held_waddr), .wdata(held_wdata),
      .raddr(held_raddr), .rdata(held_rdata));
   kblr_ram #(.WIDTH(2), .DEPTH(CODE_SPACE)) u_cls (
      .clock, .we(cls_we), .waddr(cls_waddr), .wdata(cls_wdata),
      .raddr(cls_raddr), .rdata(cls_rdata));
   kblr_ram #(.WIDTH(MAP_W), .DEPTH(MAP_DEPTH)) u_map (
      .clock, .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
      .raddr(map_raddr), .rdata(map_rdata));
   kblr_ram #(.WIDTH(1), .DEPTH(CODE_SPACE)) u_newk (
      .clock, .we(newk_we), .waddr(newk_waddr), .wdata(newk_wdata),
      .raddr(idx_ff), .rdata(newk_rd));
   kblr_ram #(.WIDTH(1), .DEPTH(CODE_SPACE)) u_newm (
      .clock, .we(newm_we), .waddr(newm_waddr), .wdata(newm_wdata),
      .raddr(idx_ff), .rdata(newm_rd));
   kblr_ram #(.WIDTH(1), .DEPTH(CODE_SPACE)) u_oldk (
      .clock, .we(oldk_we), .waddr(idx_ff), .wdata(oldk_wdata),
      .raddr(idx_ff), .rdata(oldk_rd));
   kblr_ram #(.WIDTH(1), .DEPTH(CODE_SPACE)) u_oldm (
      .clock, .we(oldm_we), .waddr(idx_ff), .wdata(oldm_wdata),
      .raddr(idx_ff), .rdata(oldm_rd));

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept = req_chan.valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Difference scan: the pass picks which pair of sets is compared and the direction.
   assign is_key_pass = (pass_ff == PASS_KEY_REL) || (pass_ff == PASS_KEY_PRS);
   assign is_press_pass = (pass_ff == PASS_MOD_PRS) || (pass_ff == PASS_KEY_PRS);
   assign nk_eff = newk_rd && !suppress_ff;
   assign o_bit = is_key_pass ? oldk_rd : oldm_rd;
   assign n_bit = is_key_pass ? nk_eff : newm_rd;
   assign hit = is_press_pass ? (!o_bit && n_bit) : (o_bit && !n_bit);
   assign take = (state_ff == ST_D_EV) && hit && (n_ff < NRES_W'(MAX_RESULTS));
   // A word found while one is still pending must first move the pending one out.
   assign advance = (state_ff == ST_D_EV) && (!(take && pend_valid_ff) || out_free);
   assign push_mid = advance && take && pend_valid_ff;
   assign push_last = (state_ff == ST_FLUSH) && pend_valid_ff && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == '1) state_in = ST_IDLE;
         ST_IDLE:  if (accept && req_chan.req_type == REQ_EVENT) state_in = ST_A_RD;
         ST_A_RD:  state_in = ST_A_EV;
         ST_A_EV:  state_in = (idx_ff == '1) ? ST_U_RD : ST_A_RD;
         ST_U_RD:  state_in = ST_U_WR;
         ST_U_WR:  state_in = ST_B_RD1;
         ST_B_RD1: state_in = ST_B_RD2;
         ST_B_RD2: state_in = ST_B_EV;
         ST_B_EV:  state_in = (idx_ff == '1) ? ST_DEC : ST_B_RD1;
         ST_DEC:   state_in = ST_D_RD;
         ST_D_RD:  state_in = ST_D_EV;
         ST_D_EV: begin
            if (advance) begin
               state_in = (idx_ff == '1 && pass_ff == PASS_KEY_PRS) ? ST_FLUSH : ST_D_RD;
            end
         end
         ST_FLUSH: if (!pend_valid_ff || out_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      held_we = 1'b0; cls_we = 1'b0; map_we = 1'b0;
      newk_we = 1'b0; newm_we = 1'b0; oldk_we = 1'b0; oldm_we = 1'b0;
      held_waddr = idx_ff; held_raddr = idx_ff; held_wdata = '0;
      cls_waddr = idx_ff; cls_raddr = idx_ff; cls_wdata = CLS_NORMAL;
      map_waddr = clr_ff; map_raddr = clr_ff; map_wdata = '0;
      newk_waddr = idx_ff; newk_wdata = 1'b0;
      newm_waddr = idx_ff; newm_wdata = 1'b0;
      oldk_wdata = 1'b0; oldm_wdata = 1'b0;

      clr_in = clr_ff; idx_in = idx_ff; pass_in = pass_ff;
      code_in = code_ff; action_in = action_ff; hcount_in = hcount_ff;
      shdn_in = shdn_ff; agdn_in = agdn_ff; shdn2_in = shdn2_ff;
      any_mod_in = any_mod_ff; need_s_in = need_s_ff; need_ns_in = need_ns_ff;
      suppress_in = suppress_ff; hb_in = hb_ff; n_in = n_ff;
      pend_valid_in = pend_valid_ff; pend_pr_in = pend_pr_ff; pend_code_in = pend_code_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            held_we = 1'b1; cls_we = 1'b1; map_we = 1'b1;
            newk_we = 1'b1; newm_we = 1'b1; oldk_we = 1'b1; oldm_we = 1'b1;
            held_waddr = clr_ff[CODE_W-1:0];
            cls_waddr = clr_ff[CODE_W-1:0];
            newk_waddr = clr_ff[CODE_W-1:0];
            newm_waddr = clr_ff[CODE_W-1:0];
            idx_in = clr_ff[CODE_W-1:0] + 1'b1;
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               code_in = req_chan.key_code;
               action_in = req_chan.action;
               idx_in = '0; pass_in = PASS_MOD_REL; n_in = '0;
               shdn_in = 1'b0; agdn_in = 1'b0; shdn2_in = 1'b0;
               any_mod_in = 1'b0; need_s_in = 1'b0; need_ns_in = 1'b0;
               suppress_in = 1'b0;
               if (32'(req_chan.key_code) < KEY_CODES) begin
                  if (req_chan.req_type == REQ_MAP) begin
                     map_we = 1'b1;
                     map_waddr = {req_chan.key_code, req_chan.entry_shift,
                                  req_chan.entry_altgr};
                     map_wdata = {req_chan.entry_found, req_chan.entry_target,
                                  req_chan.entry_needs_shift};
                  end else if (req_chan.req_type == REQ_CLASS) begin
                     cls_we = 1'b1;
                     cls_waddr = req_chan.key_code;
                     cls_wdata = req_chan.class_value;
                  end
               end
            end
         end
         ST_A_RD: begin
            // The new sets are cleared on the way through the first scan.
            newk_we = 1'b1; newm_we = 1'b1;
         end
         ST_A_EV: begin
            if (held_rd.held && cls_eff(idx_ff, cls_rdata) == CLS_SHIFT) shdn_in = 1'b1;
            if (held_rd.held && cls_eff(idx_ff, cls_rdata) == CLS_ALTGR) agdn_in = 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         ST_U_RD: begin
            held_raddr = code_ff;
            cls_raddr = code_ff;
            map_raddr = {code_ff, shdn_ff, agdn_ff};
         end
         ST_U_WR: begin
            held_waddr = code_ff;
            if (32'(code_ff) < KEY_CODES && action_ff == ACT_PRESS) begin
               if (held_rd.held || hcount_ff < HC_W'(MAX_HELD)) begin
                  if (!held_rd.held) hcount_in = hcount_ff + 1'b1;
                  held_we = 1'b1;
                  held_wdata.held = 1'b1;
                  if (cls_rdata != CLS_SHIFT && cls_rdata != CLS_ALTGR) begin
                     held_wdata.has_out = 1'b1;
                     if (map_rdata[MAP_W-1]) begin
                        held_wdata.target = map_rdata[MAP_W-2:1];
                        held_wdata.needs_shift = map_rdata[0];
                     end else begin
                        held_wdata.target = code_ff;
                        held_wdata.needs_shift = shdn_ff;
                     end
                  end
               end
            end else if (32'(code_ff) < KEY_CODES && action_ff == ACT_RELEASE) begin
               if (held_rd.held) begin
                  held_we = 1'b1;
                  if (hcount_ff != '0) hcount_in = hcount_ff - 1'b1;
               end
            end
         end
         ST_B_RD1: begin
         end
         ST_B_RD2: begin
            hb_in = held_rd;
            if (held_rd.held && cls_eff(idx_ff, cls_rdata) == CLS_SHIFT) shdn2_in = 1'b1;
            cls_raddr = held_rd.target;
         end
         ST_B_EV: begin
            if (hb_ff.held && hb_ff.has_out) begin
               if (cls_eff(hb_ff.target, cls_rdata) != CLS_NORMAL) begin
                  newm_we = 1'b1; newm_waddr = hb_ff.target; newm_wdata = 1'b1;
                  any_mod_in = 1'b1;
               end else begin
                  newk_we = 1'b1; newk_waddr = hb_ff.target; newk_wdata = 1'b1;
                  if (hb_ff.needs_shift) need_s_in = 1'b1;
                  else need_ns_in = 1'b1;
               end
            end
            idx_in = idx_ff + 1'b1;
         end
         ST_DEC: begin
            newm_waddr = shift_out_code; newm_wdata = 1'b1;
            if (any_mod_ff && shdn2_ff) begin
               newm_we = 1'b1;
            end else if (need_s_ff && need_ns_ff) begin
               suppress_in = 1'b1;
            end else if (need_s_ff || (shdn2_ff && !need_ns_ff)) begin
               newm_we = 1'b1;
            end
         end
         ST_D_RD: begin
         end
         ST_D_EV: begin
            if (advance) begin
               // The old sets take the new values only as the scan moves on.
               if (pass_ff == PASS_MOD_PRS) begin
                  oldm_we = 1'b1; oldm_wdata = newm_rd;
               end
               if (pass_ff == PASS_KEY_PRS) begin
                  oldk_we = 1'b1; oldk_wdata = nk_eff;
               end
               if (take) begin
                  pend_valid_in = 1'b1;
                  pend_code_in = idx_ff;
                  pend_pr_in = is_press_pass;
                  n_in = n_ff + 1'b1;
               end
               idx_in = idx_ff + 1'b1;
               if (idx_ff == '1) pass_in = pass_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            if (push_last) pend_valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in = rsp_code_ff;
      rsp_pr_in = rsp_pr_ff;
      rsp_last_in = rsp_last_ff;
      if (push_mid || push_last) begin
         rsp_valid_in = 1'b1;
         rsp_code_in = pend_code_ff;
         rsp_pr_in = pend_pr_ff;
         rsp_last_in = push_last;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         hcount_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         hcount_ff <= hcount_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; pass_ff <= pass_in;
      code_ff <= code_in; action_ff <= action_in;
      shdn_ff <= shdn_in; agdn_ff <= agdn_in; shdn2_ff <= shdn2_in;
      any_mod_ff <= any_mod_in; need_s_ff <= need_s_in; need_ns_ff <= need_ns_in;
      suppress_ff <= suppress_in; hb_ff <= hb_in; n_ff <= n_in;
      pend_pr_ff <= pend_pr_in; pend_code_ff <= pend_code_in;
      rsp_code_ff <= rsp_code_in; rsp_pr_ff <= rsp_pr_in; rsp_last_ff <= rsp_last_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.out_code = rsp_code_ff;
   assign rsp_chan.out_pressed = rsp_pr_ff;
   assign rsp_chan.last = rsp_last_ff;

`ifndef SYNTHESIS
   a_hcount_bound: assert property (@(posedge clock) disable iff (reset)
      hcount_ff <= HC_W'(MAX_HELD)) else $error("held count beyond limit");
   a_nres_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NRES_W'(MAX_RESULTS)) else $error("result count beyond limit");
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff) else $error("word left pending at idle");
   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (push_mid || push_last) |=> rsp_chan.valid) else $error("pushed word not shown");
`endif

endmodule
`default_nettype wire
